/* hw/rtl/tgec_pkg.sv */
// Shared types, constants and helpers for the time gap event clusterer.
// No dependencies; used by every module of the block.
`default_nettype none

package tgec_pkg;

  localparam int unsigned MaxEventsDef = 64;

  localparam int unsigned DetW   = 3;
  localparam int unsigned EnW    = 16;
  localparam int unsigned SecW   = 32;
  localparam int unsigned NsW    = 30;
  localparam int unsigned NumW   = 32;
  localparam int unsigned GapW   = 32;
  localparam int unsigned GsizeW = 7;

  // signed width of the time step; covers -2.1e9 .. +6.1e9 ns
  localparam int unsigned StepW = 36;

  localparam int unsigned InDataW  = 112;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 120;
  localparam int unsigned OutUserW = 2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DETECTOR  = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_GAP       = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  localparam logic [DetW-1:0] DetSelRst = 3'd1;
  localparam logic [EnW-1:0]  ThreshRst = 16'd700;
  localparam logic [GapW-1:0] GapRst    = 32'd1000000;

  typedef struct packed {
    logic [NumW-1:0] num;
    logic [EnW-1:0]  energy;
    logic [NsW-1:0]  ns;
    logic [SecW-1:0] sec;
  } entry_t;

  // seconds difference of -1..5 (index = difference + 1) in nanoseconds
  function automatic logic signed [StepW-1:0] sec_ns(input logic [2:0] idx);
    logic signed [StepW-1:0] r;
    r = '0;
    case (idx)
      3'd0:    r = -36'sd1000000000;
      3'd1:    r = 36'sd0;
      3'd2:    r = 36'sd1000000000;
      3'd3:    r = 36'sd2000000000;
      3'd4:    r = 36'sd3000000000;
      3'd5:    r = 36'sd4000000000;
      3'd6:    r = 36'sd5000000000;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tgec_gap_cmp.sv */
// Two-stage time step compare: new event time against the last stored one.
// Depends on tgec_pkg. The differences, then the result, are registered.
`default_nettype none

module tgec_gap_cmp (
  input  wire logic                        clk_i,
  input  wire logic [tgec_pkg::SecW-1:0]   sec_i,
  input  wire logic [tgec_pkg::NsW-1:0]    ns_i,
  input  wire logic [tgec_pkg::SecW-1:0]   last_sec_i,
  input  wire logic [tgec_pkg::NsW-1:0]    last_ns_i,
  input  wire logic [tgec_pkg::GapW-1:0]   gap_i,
  output logic                             gt_o
);

  logic signed [tgec_pkg::SecW:0]         dsec_d, dsec_q;
  logic signed [tgec_pkg::NsW:0]          dns_d, dns_q;
  logic signed [tgec_pkg::StepW-1:0]      step;
  logic                                   gt_d, gt_q;

  assign dsec_d = $signed({1'b0, sec_i}) - $signed({1'b0, last_sec_i});
  assign dns_d  = $signed({1'b0, ns_i}) - $signed({1'b0, last_ns_i});

  always_ff @(posedge clk_i) begin
    dsec_q <= dsec_d;
    dns_q  <= dns_d;
    gt_q   <= gt_d;
  end

  // Six or more seconds always exceeds any 32-bit gap; minus two or less is negative.
  always_comb begin
    step = tgec_pkg::sec_ns(dsec_q[2:0] + 3'd1)
         + tgec_pkg::StepW'(dns_q);
    if (dsec_q >= 33'sd6) begin
      gt_d = 1'b1;
    end else if (dsec_q <= -33'sd2) begin
      gt_d = 1'b0;
    end else begin
      gt_d = step > $signed({{(tgec_pkg::StepW-tgec_pkg::GapW){1'b0}}, gap_i});
    end
  end

  assign gt_o = gt_q;

endmodule

`default_nettype wire

/* hw/rtl/tgec_buf.sv */
// Event buffer: one synchronous memory of stored event fields, one write
// and one read port, read data registered. Depends on tgec_pkg.
`default_nettype none

module tgec_buf #(
  parameter int unsigned MaxEvents = tgec_pkg::MaxEventsDef,
  localparam int unsigned AddrW    = $clog2(MaxEvents)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrW-1:0]     waddr_i,
  input  wire tgec_pkg::entry_t     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AddrW-1:0]     raddr_i,
  output tgec_pkg::entry_t          rdata_o
);

  tgec_pkg::entry_t mem_q [MaxEvents];
  tgec_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/time_gap_event_clusterer_unit.sv */
// Time gap event clusterer, top level. Depends on tgec_pkg, tgec_gap_cmp, tgec_buf.
// A rejected event is taken and dropped while idle; an accepted event passes the states
// SUB, ADD and DECIDE (two-stage time step compare, then store). A closed group drains
// beat by beat: DRAIN_RD reads the buffer memory, DRAIN_LD loads the output stage and
// waits on output stalls. Reset clears count, last time, overflow flag and output valid;
// the buffer memory is not cleared, only entries below the count are ever read.
`default_nettype none

module time_gap_event_clusterer_unit #(
  parameter int unsigned MaxEvents = tgec_pkg::MaxEventsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [tgec_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [tgec_pkg::CfgDataW-1:0]    cfg_data_i,
  // event input
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // energy_kev[15:0], trig_sec[47:16], trig_nanosec[77:48], trig_number[109:78]
  input  wire logic [tgec_pkg::InDataW-1:0]     s_axis_tdata,
  // detector[2:0], is_muon[3]
  input  wire logic [tgec_pkg::InUserW-1:0]     s_axis_tuser,
  // group members
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // group_size[6:0], out_sec[38:7], out_nanosec[68:39], out_energy_kev[84:69],
  // out_trig_number[116:85]
  output logic [tgec_pkg::OutDataW-1:0]         m_axis_tdata,
  // is_cluster[0], overflow[1]
  output logic [tgec_pkg::OutUserW-1:0]         m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int unsigned AddrW = $clog2(MaxEvents);
  localparam int unsigned CntW  = $clog2(MaxEvents + 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SUB      = 6'b000010,
    ST_ADD      = 6'b000100,
    ST_DECIDE   = 6'b001000,
    ST_DRAIN_RD = 6'b010000,
    ST_DRAIN_LD = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [tgec_pkg::DetW-1:0]  det_sel_q;
  logic [tgec_pkg::EnW-1:0]   thresh_q;
  logic [tgec_pkg::GapW-1:0]  gap_q;

  tgec_pkg::entry_t           ev_d, ev_q;
  logic [CntW-1:0]            count_q, count_d;
  logic [AddrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [tgec_pkg::SecW-1:0]  last_sec_q, last_sec_d;
  logic [tgec_pkg::NsW-1:0]   last_ns_q, last_ns_d;
  logic                       dropped_q, dropped_d;

  logic                       in_pass;
  logic                       gt;
  logic                       mem_we, mem_re;
  logic [AddrW-1:0]           mem_waddr;
  tgec_pkg::entry_t           mem_rdata;
  logic                       out_free, out_load, last_beat;

  logic                       out_valid_q, out_valid_d;
  tgec_pkg::entry_t           out_ev_q;
  logic [tgec_pkg::GsizeW-1:0] out_size_q;
  logic                       out_cluster_q, out_ovf_q, out_last_q;

  // unpack the input beat
  assign ev_d.energy = s_axis_tdata[15:0];
  assign ev_d.sec    = s_axis_tdata[47:16];
  assign ev_d.ns     = s_axis_tdata[77:48];
  assign ev_d.num    = s_axis_tdata[109:78];

  assign in_pass = (s_axis_tuser[2:0] == det_sel_q) && (s_axis_tdata[15:0] >= thresh_q)
                 && !s_axis_tuser[3];

  assign s_axis_tready = (state_q == ST_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_sel_q <= tgec_pkg::DetSelRst;
      thresh_q  <= tgec_pkg::ThreshRst;
      gap_q     <= tgec_pkg::GapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tgec_pkg::CFG_DETECTOR:  det_sel_q <= cfg_data_i[tgec_pkg::DetW-1:0];
        tgec_pkg::CFG_THRESHOLD: thresh_q  <= cfg_data_i[tgec_pkg::EnW-1:0];
        tgec_pkg::CFG_GAP:       gap_q     <= cfg_data_i[tgec_pkg::GapW-1:0];
        default: ;
      endcase
    end
  end

  tgec_gap_cmp u_gap_cmp (
    .clk_i      (clk_i),
    .sec_i      (ev_q.sec),
    .ns_i       (ev_q.ns),
    .last_sec_i (last_sec_q),
    .last_ns_i  (last_ns_q),
    .gap_i      (gap_q),
    .gt_o       (gt)
  );

  tgec_buf #(
    .MaxEvents (MaxEvents)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (ev_q),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_beat = (CntW'(rd_ptr_q) == count_q - CntW'(1));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    last_sec_d = last_sec_q;
    last_ns_d  = last_ns_q;
    dropped_d  = dropped_q;
    mem_we     = 1'b0;
    mem_waddr  = count_q[AddrW-1:0];
    mem_re     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && in_pass) begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: state_d = ST_ADD;
      ST_ADD: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if ((count_q != '0) && gt) begin
          rd_ptr_d = '0;
          state_d  = ST_DRAIN_RD;
        end else begin
          state_d = ST_IDLE;
          if (count_q == CntW'(MaxEvents)) begin
            dropped_d = 1'b1;
          end else begin
            mem_we     = 1'b1;
            count_d    = count_q + CntW'(1);
            last_sec_d = ev_q.sec;
            last_ns_d  = ev_q.ns;
          end
        end
      end
      ST_DRAIN_RD: begin
        mem_re  = 1'b1;
        state_d = ST_DRAIN_LD;
      end
      ST_DRAIN_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last_beat) begin
            // group gone: the held event opens the next one
            mem_we     = 1'b1;
            mem_waddr  = '0;
            count_d    = CntW'(1);
            dropped_d  = 1'b0;
            last_sec_d = ev_q.sec;
            last_ns_d  = ev_q.ns;
            state_d    = ST_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q + AddrW'(1);
            state_d  = ST_DRAIN_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      rd_ptr_q   <= '0;
      last_sec_q <= '0;
      last_ns_q  <= '0;
      dropped_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_ptr_q   <= rd_ptr_d;
      last_sec_q <= last_sec_d;
      last_ns_q  <= last_ns_d;
      dropped_q  <= dropped_d;
    end
  end

  // hold the event taken from the input
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ev_q <= ev_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ev_q      <= mem_rdata;
      out_size_q    <= tgec_pkg::GsizeW'(count_q);
      out_cluster_q <= (count_q > CntW'(1));
      out_ovf_q     <= dropped_q;
      out_last_q    <= last_beat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_ev_q.num, out_ev_q.energy, out_ev_q.ns,
                          out_ev_q.sec, out_size_q};
  assign m_axis_tuser  = {out_ovf_q, out_cluster_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

/* test/time_gap_event_clusterer_unit_tb.sv */
// Self-checking bench for time_gap_event_clusterer_unit: directed table, then random
// event groups under several register settings, checked beat by beat against a predictor.
// Depends on tgec_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module testbench;
  import tgec_pkg::*;

  localparam int unsigned MaxEv       = MaxEventsDef;
  localparam longint      NsPerSec    = 64'sd1000000000;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned SettleCyc   = 16;
  localparam int unsigned DirRows     = 16;

  typedef struct packed {
    logic [DetW-1:0] det;
    logic [EnW-1:0]  energy;
    logic            muon;
    logic [SecW-1:0] sec;
    logic [NsW-1:0]  ns;
    logic [NumW-1:0] num;
  } trig_event_t;

  typedef struct packed {
    logic              is_cluster;
    logic [GsizeW-1:0] gsize;
    logic [SecW-1:0]   sec;
    logic [NsW-1:0]    ns;
    logic [EnW-1:0]    energy;
    logic [NumW-1:0]   num;
    logic              overflow;
    logic              last;
  } member_t;

  typedef struct packed {
    trig_event_t ev;
    logic        typed;
    member_t     want;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = CFG_DETECTOR;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tlast;

  time_gap_event_clusterer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers and the group store
  logic [DetW-1:0] cfg_sel = DetSelRst;
  logic [EnW-1:0]  cfg_thr = ThreshRst;
  logic [GapW-1:0] cfg_gap = GapRst;
  trig_event_t     grp_buf [MaxEv];
  int              grp_count   = 0;
  logic [SecW-1:0] last_sec    = '0;
  logic [NsW-1:0]  last_ns     = '0;
  logic            grp_dropped = 1'b0;

  member_t     members_due[$];
  int          mismatches = 0;
  int unsigned cycle_cnt  = 0;
  bit          src_calm   = 1'b0;
  bit          sink_calm  = 1'b0;
  int          sink_hold  = 0;
  longint      now_ns     = 0;

  // hand-worked rows at reset settings: detector 1, threshold 700, gap 1 ms
  dir_row_t dir_tab [DirRows] = '{
    '{'{3'd1, 16'd700,   1'b0, 32'd10, 30'd0,       32'h101}, 1'b0, '0},
    '{'{3'd1, 16'd699,   1'b0, 32'd10, 30'd5,       32'h102}, 1'b0, '0},
    '{'{3'd2, 16'd5000,  1'b0, 32'd10, 30'd6,       32'h103}, 1'b0, '0},
    '{'{3'd1, 16'd5000,  1'b1, 32'd10, 30'd7,       32'h104}, 1'b0, '0},
    '{'{3'd1, 16'd65535, 1'b0, 32'd10, 30'd1000000, 32'h105}, 1'b0, '0},
    '{'{3'd1, 16'd800,   1'b0, 32'd10, 30'd2000001, 32'h106}, 1'b0, '0},
    '{'{3'd1, 16'd900,   1'b0, 32'd10, 30'd1,       32'h107}, 1'b0, '0},
    '{'{3'd1, 16'd1000,  1'b0, 32'd11, 30'd1,       32'h108}, 1'b0, '0},
    '{'{3'd1, 16'd700,   1'b0, 32'd12, 30'd0,       32'h109}, 1'b1,
      '{1'b0, 7'd1, 32'd11, 30'd1, 16'd1000, 32'h108, 1'b0, 1'b1}},
    '{'{3'd1, 16'd700,   1'b0, 32'd12, 30'h3FFFFFFF, 32'h10A}, 1'b1,
      '{1'b0, 7'd1, 32'd12, 30'd0, 16'd700, 32'h109, 1'b0, 1'b1}},
    '{'{3'd1, 16'd65535, 1'b0, 32'hFFFFFFFF, 30'd999999999, 32'hFFFFFFFF}, 1'b1,
      '{1'b0, 7'd1, 32'd12, 30'h3FFFFFFF, 16'd700, 32'h10A, 1'b0, 1'b1}},
    '{'{3'd1, 16'd700,   1'b0, 32'd0,  30'd0,       32'h0},   1'b0, '0},
    '{'{3'd1, 16'd700,   1'b0, 32'd0,  30'd0,       32'h10C}, 1'b0, '0},
    '{'{3'd0, 16'd0,     1'b1, 32'd0,  30'd0,       32'h10D}, 1'b0, '0},
    '{'{3'd7, 16'd65535, 1'b0, 32'd0,  30'd0,       32'h10E}, 1'b0, '0},
    '{'{3'd1, 16'd701,   1'b0, 32'd0,  30'd1000001, 32'h10F}, 1'b0, '0}
  };

  // work out the members emitted by one event and advance the group state
  function automatic void cluster_step(input trig_event_t ev, input bit record);
    longint  a_sec, b_sec, a_ns, b_ns, span, gap;
    member_t m;
    if (ev.det != cfg_sel || ev.energy < cfg_thr || ev.muon) return;
    if (grp_count > 0) begin
      a_sec = ev.sec;
      b_sec = last_sec;
      a_ns  = ev.ns;
      b_ns  = last_ns;
      gap   = cfg_gap;
      span  = (a_sec - b_sec) * NsPerSec + (a_ns - b_ns);
      if (span > gap) begin
        for (int k = 0; k < grp_count; k++) begin
          m.is_cluster = (grp_count > 1);
          m.gsize      = GsizeW'(grp_count);
          m.sec        = grp_buf[k].sec;
          m.ns         = grp_buf[k].ns;
          m.energy     = grp_buf[k].energy;
          m.num        = grp_buf[k].num;
          m.overflow   = grp_dropped;
          m.last       = (k == grp_count - 1);
          if (record) members_due = {members_due, m};
        end
        grp_count   = 0;
        grp_dropped = 1'b0;
      end
    end
    if (grp_count >= MaxEv) begin
      grp_dropped = 1'b1;
    end else begin
      grp_buf[grp_count] = ev;
      grp_count++;
      last_sec = ev.sec;
      last_ns  = ev.ns;
    end
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : member_check
    member_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.is_cluster = m_axis_tuser[0];
      got.overflow   = m_axis_tuser[1];
      got.gsize      = m_axis_tdata[6:0];
      got.sec        = m_axis_tdata[38:7];
      got.ns         = m_axis_tdata[68:39];
      got.energy     = m_axis_tdata[84:69];
      got.num        = m_axis_tdata[116:85];
      got.last       = m_axis_tlast;
      if (members_due.size() == 0) begin
        $error("group member beat with nothing due, trig_number %0d", got.num);
        mismatches++;
      end else begin
        want = members_due.pop_front();
        check_field("is_cluster", want.is_cluster, got.is_cluster);
        check_field("group_size", want.gsize, got.gsize);
        check_field("out_sec", want.sec, got.sec);
        check_field("out_nanosec", want.ns, got.ns);
        check_field("out_energy_kev", want.energy, got.energy);
        check_field("out_trig_number", want.num, got.num);
        check_field("overflow", want.overflow, got.overflow);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("time_gap_event_clusterer_unit verification failed");
      $finish;
    end
  end

  // receiver: random stall per beat, or a long hold-off when asked
  initial begin : sink
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
      end
      stall = sink_calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready) && sink_hold == 0);
    end
  end

  task automatic send_event(input trig_event_t ev, input bit typed, input member_t want);
    int idle;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, ev.num, ev.ns, ev.sec, ev.energy};
    s_axis_tuser  <= {ev.muon, ev.det};
    do @(posedge clk_i); while (!s_axis_tready);
    cluster_step(ev, !typed);
    if (typed) members_due = {members_due, want};
    idle = src_calm ? 0 : $urandom_range(0, 16);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // an event the block must drop: wrong detector, vetoed or below threshold
  function automatic trig_event_t noise_event();
    trig_event_t ev;
    ev.det    = cfg_sel;
    ev.energy = EnW'($urandom_range(0, 65535));
    ev.muon   = 1'b1;
    ev.sec    = $urandom;
    ev.ns     = NsW'($urandom_range(0, 30'h3FFFFFFF));
    ev.num    = $urandom;
    case ($urandom_range(0, 2))
      0: begin
        ev.det  = cfg_sel + DetW'($urandom_range(1, 7));
        ev.muon = 1'($urandom_range(0, 1));
      end
      1: ;
      default: begin
        if (cfg_thr > 0) begin
          ev.energy = EnW'($urandom_range(0, cfg_thr - 1));
          ev.muon   = 1'b0;
        end
      end
    endcase
    return ev;
  endfunction

  // one group: the first member steps past the gap or jumps to a random time, the rest step within the gap or back
  task automatic send_group(input int members);
    trig_event_t ev;
    longint      step, gap;
    gap = cfg_gap;
    for (int k = 0; k < members; k++) begin
      if ($urandom_range(0, 4) == 0) send_event(noise_event(), 1'b0, '0);
      step = 0;
      if (k == 0) begin
        if ($urandom_range(0, 5) == 0)
          now_ns = longint'($urandom) * NsPerSec + $urandom_range(0, 999999999);
        else
          step = gap + 1 + $urandom_range(0, 50000);
      end else if ($urandom_range(0, 9) == 0) begin
        step = -longint'($urandom_range(1, 1500000000));
      end else begin
        step = $urandom_range(0, cfg_gap);
      end
      now_ns = now_ns + step;
      if (now_ns < 0) now_ns = 0;
      ev.det    = cfg_sel;
      ev.energy = EnW'($urandom_range(cfg_thr, 65535));
      ev.muon   = 1'b0;
      ev.sec    = SecW'(now_ns / NsPerSec);
      ev.ns     = NsW'(now_ns % NsPerSec);
      if ($urandom_range(0, 19) == 0) ev.ns = NsW'($urandom_range(1000000000, 30'h3FFFFFFF));
      ev.num = $urandom;
      send_event(ev, 1'b0, '0);
    end
  endtask

  task automatic run_random(input int accepted);
    int made, members;
    made = 0;
    while (made < accepted) begin
      members   = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      send_group(members);
      made += members;
    end
  endtask

  // drop valid, wait for every due member, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (members_due.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DETECTOR:  cfg_sel = value[DetW-1:0];
      CFG_THRESHOLD: cfg_thr = value[EnW-1:0];
      CFG_GAP:       cfg_gap = value[GapW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++)
      send_event(dir_tab[r].ev, dir_tab[r].typed, dir_tab[r].want);
    settle();

    cfg_write(CFG_DETECTOR, 32'd3);
    cfg_write(CFG_THRESHOLD, 32'd0);
    cfg_write(CFG_GAP, 32'd0);
    now_ns = longint'($urandom) * NsPerSec;
    run_random(3);
    settle();

    cfg_write(CFG_DETECTOR, 32'd7);
    cfg_write(CFG_THRESHOLD, 32'hFFFF);
    cfg_write(CFG_GAP, 32'hFFFFFFFF);
    run_random(3);
    settle();

    cfg_write(CFG_DETECTOR, 32'd0);
    cfg_write(CFG_THRESHOLD, 32'd1000);
    cfg_write(CFG_GAP, 32'd5000);
    run_random(3);
    settle();

    cfg_write(CFG_DETECTOR, 32'd5);
    cfg_write(CFG_THRESHOLD, 32'd300);
    cfg_write(CFG_GAP, 32'd2000000);
    run_random(3);
    settle();

    // send more group members than the buffer holds while the receiver holds off, so the drain backs up the input
    cfg_write(CFG_DETECTOR, 32'd2);
    cfg_write(CFG_THRESHOLD, 32'd100);
    cfg_write(CFG_GAP, 32'd1000);
    src_calm  = 1'b1;
    sink_calm = 1'b0;
    sink_hold = 400;
    send_group(MaxEv + 2);
    send_group(1);
    settle();

    if (mismatches == 0 && members_due.size() == 0)
      $display("time_gap_event_clusterer_unit verification clean");
    else
      $display("time_gap_event_clusterer_unit verification failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tgec_pkg.sv
hw/rtl/tgec_gap_cmp.sv
hw/rtl/tgec_buf.sv
hw/rtl/time_gap_event_clusterer_unit.sv
test/time_gap_event_clusterer_unit_tb.sv
